// ===== rtl/core/spl_pkg.sv =====
package spl_pkg;

	// Default sizes
	localparam int DEF_PAGE_BYTES   = 128;
	localparam int DEF_BUFFER_BYTES = 256;

	// Register indexes on the configuration port
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_NODE_ID = 1'b1;

	localparam logic [23:0] TIMEOUT_RESET = 24'd100000;
	localparam logic [39:0] NODE_ID_RESET = 40'h4B53310000;

	// Input kinds
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// Protocol bytes
	localparam logic [7:0] BYTE_ENQ   = 8'd5;
	localparam logic [7:0] BYTE_ACK   = 8'd6;
	localparam logic [7:0] BYTE_BEL   = 8'd7;
	localparam logic [7:0] BYTE_BS    = 8'd8;
	localparam logic [7:0] BYTE_COLON = 8'h3A;
	localparam logic [7:0] BYTE_S     = 8'h53;
	localparam logic [7:0] BYTE_T     = 8'h54;

	// Id sequence: five id bytes, then 'T' at this count
	localparam int ID_LAST = 5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHAKE,
		ST_COLON,
		ST_LEN,
		ST_ALO,
		ST_AHI,
		ST_SUM,
		ST_DATA,
		ST_DONE,
		ST_ID,
		ST_PG_RD,
		ST_PG_OUT
	} state_t;

	typedef enum logic [1:0] {
		OUT_TX,
		OUT_APP,
		OUT_ID,
		OUT_WORD
	} out_sel_t;

	typedef struct packed {
		logic       wait_clr;
		logic       wait_inc;
		logic       len_ld;
		logic       alo_ld;
		logic       ahi_ld;
		logic       sum_init;
		logic       sum_add;
		logic       idx_clr;
		logic       buf_wr;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       rd;
		logic       out_ld;
		out_sel_t   out_sel;
		logic [7:0] tx_code;
		logic       tx_app;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic expired;
		logic sum_ok;
		logic len_zero;
		logic data_end;
		logic id_last;
		logic pg_last;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== rtl/core/spl_ram.sv =====
module spl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/spl_dpath.sv =====
module spl_dpath import spl_pkg::*; #(
	parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
	parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [39:0] cfg_data,
	input  logic [7:0]  rx_byte,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic        out_ready,
	output logic        out_valid,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        write_valid,
	output logic        erase_page,
	output logic [15:0] flash_address,
	output logic [15:0] flash_word,
	output logic        commit_page,
	output logic        start_app,
	output logic        last
);

	localparam int PAGE_WORDS = PAGE_BYTES / 2;
	localparam int CNT_MAX    = (PAGE_WORDS > ID_LAST + 1) ? PAGE_WORDS : ID_LAST + 1;
	localparam int CW         = $clog2(CNT_MAX);
	localparam int EVEN_D     = (BUFFER_BYTES + 1) / 2;
	localparam int ODD_D      = BUFFER_BYTES / 2;
	localparam int AWE        = $clog2(EVEN_D);
	localparam int AWO        = $clog2(ODD_D);
	localparam int BW         = $clog2(BUFFER_BYTES);

	logic [23:0]  timeout_q;
	logic [39:0]  node_id_q;
	logic [23:0]  wait_q;
	logic [23:0]  wait_nx;
	logic [7:0]   len_q;
	logic [15:0]  addr_q;
	logic [7:0]   sum_q;
	logic [7:0]   idx_q;
	logic [CW-1:0] cnt_q;
	logic [BUFFER_BYTES-1:0] valid_q;
	logic         rv_lo_q;
	logic         rv_hi_q;
	logic         store;
	logic         we_even;
	logic         we_odd;
	logic [7:0]   even_rdata;
	logic [7:0]   odd_rdata;
	logic [7:0]   node_byte;
	logic         out_valid_q;

	logic         tx_valid_d;
	logic [7:0]   tx_byte_d;
	logic         write_valid_d;
	logic         erase_page_d;
	logic [15:0]  flash_address_d;
	logic [15:0]  flash_word_d;
	logic         commit_page_d;
	logic         start_app_d;

	logic         tx_valid_q;
	logic [7:0]   tx_byte_q;
	logic         write_valid_q;
	logic         erase_page_q;
	logic [15:0]  flash_address_q;
	logic [15:0]  flash_word_q;
	logic         commit_page_q;
	logic         start_app_q;
	logic         last_q;

	// saturating tick count
	assign wait_nx = (wait_q == '1) ? wait_q : wait_q + 24'd1;

	assign sts.expired  = wait_nx >= timeout_q;
	assign sts.sum_ok   = (sum_q + rx_byte) == 8'd0;
	assign sts.len_zero = len_q == 8'd0;
	assign sts.data_end = (9'(idx_q) + 9'd1) >= 9'(len_q);
	assign sts.id_last  = cnt_q == CW'(ID_LAST);
	assign sts.pg_last  = cnt_q == CW'(PAGE_WORDS - 1);
	assign sts.out_free = !out_valid_q || out_ready;

	assign store   = cmd.buf_wr && (9'(idx_q) < 9'(BUFFER_BYTES));
	assign we_even = store && !idx_q[0];
	assign we_odd  = store && idx_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			node_id_q   <= NODE_ID_RESET;
			wait_q      <= '0;
			len_q       <= '0;
			addr_q      <= '0;
			sum_q       <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data[23:0];
					REG_NODE_ID: node_id_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.wait_clr) begin
				wait_q <= '0;
			end else if (cmd.wait_inc) begin
				wait_q <= wait_nx;
			end
			if (cmd.len_ld) begin
				len_q <= rx_byte;
			end
			if (cmd.alo_ld) begin
				addr_q[7:0] <= rx_byte;
			end
			if (cmd.ahi_ld) begin
				addr_q[15:8] <= rx_byte;
			end
			if (cmd.sum_init) begin
				sum_q <= rx_byte;
			end else if (cmd.sum_add) begin
				sum_q <= sum_q + rx_byte;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.buf_wr) begin
				idx_q <= idx_q + 8'd1;
			end
			if (store) begin
				valid_q[idx_q[BW-1:0]] <= 1'b1;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// buffer split into even and odd byte banks so one word reads in a cycle
	spl_ram #(.WIDTH(8), .DEPTH(EVEN_D)) u_even (
		.clk   (clk),
		.we    (we_even),
		.waddr (idx_q[AWE:1]),
		.wdata (rx_byte),
		.re    (cmd.rd),
		.raddr (AWE'(cnt_q)),
		.rdata (even_rdata)
	);

	spl_ram #(.WIDTH(8), .DEPTH(ODD_D)) u_odd (
		.clk   (clk),
		.we    (we_odd),
		.waddr (idx_q[AWO:1]),
		.wdata (rx_byte),
		.re    (cmd.rd),
		.raddr (AWO'(cnt_q)),
		.rdata (odd_rdata)
	);

	// never-written bytes read as zero
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rv_lo_q <= valid_q[BW'({cnt_q, 1'b0})];
			rv_hi_q <= valid_q[BW'({cnt_q, 1'b1})];
		end
	end

	always_comb begin
		case (cnt_q)
			CW'(0):  node_byte = node_id_q[39:32];
			CW'(1):  node_byte = node_id_q[31:24];
			CW'(2):  node_byte = node_id_q[23:16];
			CW'(3):  node_byte = node_id_q[15:8];
			CW'(4):  node_byte = node_id_q[7:0];
			default: node_byte = BYTE_T;
		endcase
	end

	always_comb begin
		tx_valid_d      = 1'b0;
		tx_byte_d       = '0;
		write_valid_d   = 1'b0;
		erase_page_d    = 1'b0;
		flash_address_d = '0;
		flash_word_d    = '0;
		commit_page_d   = 1'b0;
		start_app_d     = 1'b0;
		unique case (cmd.out_sel)
			OUT_TX: begin
				tx_valid_d  = 1'b1;
				tx_byte_d   = cmd.tx_code;
				start_app_d = cmd.tx_app;
			end
			OUT_APP: begin
				start_app_d = 1'b1;
			end
			OUT_ID: begin
				tx_valid_d = 1'b1;
				tx_byte_d  = node_byte;
			end
			OUT_WORD: begin
				write_valid_d   = 1'b1;
				erase_page_d    = cnt_q == '0;
				flash_address_d = addr_q + 16'({cnt_q, 1'b0});
				flash_word_d    = {rv_hi_q ? odd_rdata : 8'd0, rv_lo_q ? even_rdata : 8'd0};
				commit_page_d   = cmd.out_last;
				tx_valid_d      = cmd.out_last;
				tx_byte_d       = cmd.out_last ? BYTE_T : 8'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			tx_valid_q      <= tx_valid_d;
			tx_byte_q       <= tx_byte_d;
			write_valid_q   <= write_valid_d;
			erase_page_q    <= erase_page_d;
			flash_address_q <= flash_address_d;
			flash_word_q    <= flash_word_d;
			commit_page_q   <= commit_page_d;
			start_app_q     <= start_app_d;
			last_q          <= cmd.out_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_valid      = tx_valid_q;
	assign tx_byte       = tx_byte_q;
	assign write_valid   = write_valid_q;
	assign erase_page    = erase_page_q;
	assign flash_address = flash_address_q;
	assign flash_word    = flash_word_q;
	assign commit_page   = commit_page_q;
	assign start_app     = start_app_q;
	assign last          = last_q;

endmodule

// ===== rtl/core/spl_ctrl.sv =====
module spl_ctrl import spl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] rx_byte,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	state_t st_q;
	state_t st_d;
	logic   proto;
	logic   in_frame;
	logic   acc;

	assign proto    = (st_q != ST_ID) && (st_q != ST_PG_RD) && (st_q != ST_PG_OUT);
	assign in_frame = (st_q == ST_COLON) || (st_q == ST_LEN) || (st_q == ST_ALO) ||
		(st_q == ST_AHI) || (st_q == ST_SUM) || (st_q == ST_DATA);
	assign in_ready = proto && sts.out_free;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		if (acc) begin
			unique case (action)
				ACT_START: st_d = ST_SHAKE;
				ACT_TICK: begin
					if (sts.expired) begin
						if (st_q == ST_SHAKE) begin
							st_d = ST_DONE;
						end else if (in_frame) begin
							st_d = ST_COLON;
						end
					end
				end
				ACT_BYTE: begin
					unique case (st_q)
						ST_SHAKE: st_d = (rx_byte == BYTE_ACK) ? ST_ID : ST_DONE;
						ST_COLON: if (rx_byte == BYTE_COLON) st_d = ST_LEN;
						ST_LEN:   st_d = (rx_byte == BYTE_S) ? ST_DONE : ST_ALO;
						ST_ALO:   st_d = ST_AHI;
						ST_AHI:   st_d = ST_SUM;
						ST_SUM: begin
							if (!sts.len_zero) begin
								st_d = ST_DATA;
							end else begin
								st_d = sts.sum_ok ? ST_PG_RD : ST_COLON;
							end
						end
						ST_DATA: begin
							if (sts.data_end) begin
								st_d = sts.sum_ok ? ST_PG_RD : ST_COLON;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end else begin
			unique case (st_q)
				ST_ID:     if (sts.out_free && sts.id_last) st_d = ST_COLON;
				ST_PG_RD:  st_d = ST_PG_OUT;
				ST_PG_OUT: if (sts.out_free) st_d = sts.pg_last ? ST_COLON : ST_PG_RD;
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.out_sel  = OUT_TX;
		if (acc) begin
			unique case (action)
				ACT_START: begin
					cmd.wait_clr = 1'b1;
					cmd.out_ld   = 1'b1;
					cmd.tx_code  = BYTE_ENQ;
					cmd.out_last = 1'b1;
				end
				ACT_TICK: begin
					if (st_q == ST_SHAKE || in_frame) begin
						if (sts.expired) begin
							cmd.wait_clr = 1'b1;
							cmd.out_ld   = 1'b1;
							cmd.out_last = 1'b1;
							if (st_q == ST_SHAKE) begin
								cmd.out_sel = OUT_APP;
							end else begin
								cmd.tx_code = BYTE_BEL;
							end
						end else begin
							cmd.wait_inc = 1'b1;
						end
					end
				end
				ACT_BYTE: begin
					cmd.wait_clr = (st_q != ST_IDLE) && (st_q != ST_DONE);
					unique case (st_q)
						ST_SHAKE: begin
							if (rx_byte == BYTE_ACK) begin
								cmd.cnt_clr = 1'b1;
							end else begin
								cmd.out_ld   = 1'b1;
								cmd.out_sel  = OUT_APP;
								cmd.out_last = 1'b1;
							end
						end
						ST_LEN: begin
							cmd.len_ld = 1'b1;
							if (rx_byte == BYTE_S) begin
								cmd.out_ld   = 1'b1;
								cmd.tx_code  = BYTE_BS;
								cmd.tx_app   = 1'b1;
								cmd.out_last = 1'b1;
							end else begin
								cmd.sum_init = 1'b1;
							end
						end
						ST_ALO: begin
							cmd.alo_ld  = 1'b1;
							cmd.sum_add = 1'b1;
						end
						ST_AHI: begin
							cmd.ahi_ld  = 1'b1;
							cmd.sum_add = 1'b1;
						end
						ST_SUM, ST_DATA: begin
							cmd.sum_add = 1'b1;
							cmd.idx_clr = st_q == ST_SUM;
							cmd.buf_wr  = st_q == ST_DATA;
							if ((st_q == ST_SUM && sts.len_zero) ||
								(st_q == ST_DATA && sts.data_end)) begin
								if (sts.sum_ok) begin
									cmd.cnt_clr = 1'b1;
								end else begin
									cmd.out_ld   = 1'b1;
									cmd.tx_code  = BYTE_BEL;
									cmd.out_last = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end else begin
			unique case (st_q)
				ST_ID: begin
					if (sts.out_free) begin
						cmd.out_ld   = 1'b1;
						cmd.out_sel  = OUT_ID;
						cmd.out_last = sts.id_last;
						cmd.cnt_inc  = 1'b1;
					end
				end
				ST_PG_RD: begin
					cmd.rd = 1'b1;
				end
				ST_PG_OUT: begin
					if (sts.out_free) begin
						cmd.out_ld   = 1'b1;
						cmd.out_sel  = OUT_WORD;
						cmd.out_last = sts.pg_last;
						cmd.cnt_inc  = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/serial_page_loader_framer.sv =====
// Single result: an item that gives one result shows it in the output register in the cycle after accept.
// Handshake ack: six results, one per cycle while the output side keeps up, loaded from the ID state after accept.
// Page program: each word is a buffer read, then an output load, for PAGE_WORDS words in all.
// Throughput: one item per cycle while the output side keeps up; no item taken during emissions.
// Reset (arst_n low, async): protocol idle, counters and sums cleared, registers at defaults,
// buffer valid bits cleared so the page buffer reads as zeros; no clearing pass is needed.
module serial_page_loader_framer import spl_pkg::*; #(
	parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
	parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: index 0 timeout_ticks, index 1 node_id
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [39:0] cfg_data,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] action
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [7:0] tx_byte, [8] erase_page, [24:9] flash_address,
	                                    // [40:25] flash_word, [41] commit_page, [42] start_app
	output logic [1:0]  m_axis_tuser,   // [0] tx_valid, [1] write_valid
	output logic        m_axis_tlast
);

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        write_valid;
	logic        erase_page;
	logic [15:0] flash_address;
	logic [15:0] flash_word;
	logic        commit_page;
	logic        start_app;

	// Controller: protocol phases plus the id and page emission sequences.
	// Input is taken only in a protocol phase and while the output register can load.
	spl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.action   (s_axis_tuser),
		.rx_byte  (s_axis_tdata),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: timeout counter, frame fields, checksum, page buffer, output register.
	spl_dpath #(
		.PAGE_BYTES   (PAGE_BYTES),
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rx_byte       (s_axis_tdata),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.tx_valid      (tx_valid),
		.tx_byte       (tx_byte),
		.write_valid   (write_valid),
		.erase_page    (erase_page),
		.flash_address (flash_address),
		.flash_word    (flash_word),
		.commit_page   (commit_page),
		.start_app     (start_app),
		.last          (m_axis_tlast)
	);

	// pack result fields, lowest field first, zero fill to whole bytes
	assign m_axis_tdata = {5'd0, start_app, commit_page, flash_word, flash_address,
		erase_page, tx_byte};
	assign m_axis_tuser = {write_valid, tx_valid};

endmodule

// ===== dv/spl_loader_checker.sv =====
module spl_loader_checker import spl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_axis_tuser,   // [1:0] action
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,   // [7:0] tx_byte, [8] erase_page, [24:9] flash_address,
	                                    // [40:25] flash_word, [41] commit_page, [42] start_app
	input  logic [1:0]  m_axis_tuser,   // [0] tx_valid, [1] write_valid
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          results_pending
);

	localparam int PAGE_WORDS = DEF_PAGE_BYTES / 2;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        write_valid;
		logic        erase_page;
		logic [15:0] flash_address;
		logic [15:0] flash_word;
		logic        commit_page;
		logic        start_app;
		logic        last;
	} loader_out_t;

	loader_out_t awaited_results[$];

	// shadow of the loader state
	state_t      phase_q;
	logic [23:0] idle_ticks;
	logic [7:0]  frm_len;
	logic [15:0] page_base;
	logic [7:0]  byte_sum;
	logic [7:0]  data_pos;
	logic [7:0]  page_mem [DEF_BUFFER_BYTES];
	logic [23:0] timeout_cfg;
	logic [39:0] node_cfg;

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic push_tx(input logic [7:0] code, input logic app);
		loader_out_t r;
		r = '0;
		r.tx_valid  = 1'b1;
		r.tx_byte   = code;
		r.start_app = app;
		awaited_results.push_back(r);
	endtask

	task automatic push_app();
		loader_out_t r;
		r = '0;
		r.start_app = 1'b1;
		awaited_results.push_back(r);
	endtask

	task automatic count_tick(output logic expired);
		if (idle_ticks != 24'hFFFFFF)
			idle_ticks = idle_ticks + 24'd1;
		expired = (idle_ticks >= timeout_cfg);
	endtask

	// checksum verdict: BEL, or a full page program with 'T' on the commit word
	task automatic close_frame();
		loader_out_t r;
		phase_q    = ST_COLON;
		idle_ticks = '0;
		if (byte_sum != 8'd0) begin
			push_tx(BYTE_BEL, 1'b0);
		end else begin
			for (int w = 0; w < PAGE_WORDS; w++) begin
				r = '0;
				r.write_valid   = 1'b1;
				r.erase_page    = (w == 0);
				r.flash_address = page_base + 16'(2 * w);
				r.flash_word    = {page_mem[2 * w + 1], page_mem[2 * w]};
				if (w == PAGE_WORDS - 1) begin
					r.commit_page = 1'b1;
					r.tx_valid    = 1'b1;
					r.tx_byte     = BYTE_T;
				end
				awaited_results.push_back(r);
			end
		end
	endtask

	task automatic loader_step(input logic [1:0] act, input logic [7:0] rx);
		int         n_prior;
		logic       expired;
		logic [8:0] next_pos;
		n_prior = awaited_results.size();
		case (act)
			ACT_START: begin
				phase_q    = ST_SHAKE;
				idle_ticks = '0;
				push_tx(BYTE_ENQ, 1'b0);
			end
			ACT_TICK: begin
				case (phase_q)
					ST_SHAKE: begin
						count_tick(expired);
						if (expired) begin
							phase_q    = ST_DONE;
							idle_ticks = '0;
							push_app();
						end
					end
					ST_COLON, ST_LEN, ST_ALO, ST_AHI, ST_SUM, ST_DATA: begin
						count_tick(expired);
						if (expired) begin
							phase_q    = ST_COLON;
							idle_ticks = '0;
							push_tx(BYTE_BEL, 1'b0);
						end
					end
					default: ;
				endcase
			end
			ACT_BYTE: begin
				if (phase_q != ST_IDLE && phase_q != ST_DONE)
					idle_ticks = '0;
				case (phase_q)
					ST_SHAKE: begin
						if (rx == BYTE_ACK) begin
							for (int k = 0; k < ID_LAST; k++)
								push_tx(node_cfg[39 - 8 * k -: 8], 1'b0);
							push_tx(BYTE_T, 1'b0);
							phase_q = ST_COLON;
						end else begin
							push_app();
							phase_q = ST_DONE;
						end
					end
					ST_COLON: begin
						if (rx == BYTE_COLON)
							phase_q = ST_LEN;
					end
					ST_LEN: begin
						frm_len = rx;
						if (rx == BYTE_S) begin
							push_tx(BYTE_BS, 1'b1);
							phase_q = ST_DONE;
						end else begin
							byte_sum = rx;
							phase_q  = ST_ALO;
						end
					end
					ST_ALO: begin
						page_base[7:0] = rx;
						byte_sum       = byte_sum + rx;
						phase_q        = ST_AHI;
					end
					ST_AHI: begin
						page_base[15:8] = rx;
						byte_sum        = byte_sum + rx;
						phase_q         = ST_SUM;
					end
					ST_SUM: begin
						byte_sum = byte_sum + rx;
						data_pos = '0;
						if (frm_len == 8'd0)
							close_frame();
						else
							phase_q = ST_DATA;
					end
					ST_DATA: begin
						page_mem[data_pos] = rx;
						byte_sum           = byte_sum + rx;
						next_pos           = {1'b0, data_pos} + 9'd1;
						data_pos           = next_pos[7:0];
						if (next_pos >= {1'b0, frm_len})
							close_frame();
					end
					default: ;
				endcase
			end
			default: ;  // unused action code
		endcase
		if (awaited_results.size() > n_prior)
			awaited_results[awaited_results.size() - 1].last = 1'b1;
	endtask

	task automatic compare_result(input loader_out_t got, input loader_out_t want);
		if (got.tx_valid != want.tx_valid)
			report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
		if (got.tx_byte != want.tx_byte)
			report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
		if (got.write_valid != want.write_valid)
			report_mismatch("write_valid", got.write_valid, want.write_valid);
		if (got.erase_page != want.erase_page)
			report_mismatch("erase_page", got.erase_page, want.erase_page);
		if (got.flash_address != want.flash_address)
			report_mismatch("flash_address", got.flash_address, want.flash_address);
		if (got.flash_word != want.flash_word)
			report_mismatch("flash_word", got.flash_word, want.flash_word);
		if (got.commit_page != want.commit_page)
			report_mismatch("commit_page", got.commit_page, want.commit_page);
		if (got.start_app != want.start_app)
			report_mismatch("start_app", got.start_app, want.start_app);
		if (got.last != want.last)
			report_mismatch("last", got.last, want.last);
	endtask

	always @(posedge clk or negedge arst_n) begin
		loader_out_t got;
		if (!arst_n) begin
			phase_q         = ST_IDLE;
			idle_ticks      = '0;
			frm_len         = '0;
			page_base       = '0;
			byte_sum        = '0;
			data_pos        = '0;
			timeout_cfg     = TIMEOUT_RESET;
			node_cfg        = NODE_ID_RESET;
			mismatches      = 0;
			for (int a = 0; a < DEF_BUFFER_BYTES; a++)
				page_mem[a] = '0;
			awaited_results.delete();
			results_pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TIMEOUT)
					timeout_cfg = cfg_data[23:0];
				else
					node_cfg = cfg_data;
			end
			// results leaving now stem from items taken at earlier edges
			if (m_axis_tvalid && m_axis_tready) begin
				got.tx_valid      = m_axis_tuser[0];
				got.write_valid   = m_axis_tuser[1];
				got.tx_byte       = m_axis_tdata[7:0];
				got.erase_page    = m_axis_tdata[8];
				got.flash_address = m_axis_tdata[24:9];
				got.flash_word    = m_axis_tdata[40:25];
				got.commit_page   = m_axis_tdata[41];
				got.start_app     = m_axis_tdata[42];
				got.last          = m_axis_tlast;
				if (awaited_results.size() == 0)
					report_mismatch("result with nothing awaited", m_axis_tdata[39:0], '0);
				else
					compare_result(got, awaited_results.pop_front());
			end
			if (s_axis_tvalid && s_axis_tready)
				loader_step(s_axis_tuser, s_axis_tdata);
			results_pending = awaited_results.size();
		end
	end

endmodule

// ===== dv/serial_page_loader_framer_tb.sv =====
module serial_page_loader_framer_tb;
	import spl_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [39:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
	logic [1:0]  s_axis_tuser;   // [1:0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // [7:0] tx_byte, [8] erase_page, [24:9] flash_address,
	                             // [40:25] flash_word, [41] commit_page, [42] start_app
	logic [1:0]  m_axis_tuser;   // [0] tx_valid, [1] write_valid
	logic        m_axis_tlast;

	int          mismatches;
	int          results_pending;

	// stimulus bookkeeping
	int          items_sent;
	logic [23:0] cur_timeout;    // timeout_ticks as last written, to aim tick runs
	bit          calm;           // no idling on either side once set
	bit          hold_wanted;    // ask the receiver for one long hold-off
	bit          hold_taken;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	serial_page_loader_framer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Checker sits beside the block: predicts every result and compares.
	spl_loader_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	// Offer one item and hold it until the block takes it. A random idle gap
	// may come first, unless the run is in its calm tail.
	task automatic send_item(input logic [1:0] act, input logic [7:0] rx);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= rx;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_item(ACT_TICK, 8'($urandom));
	endtask

	// Stop offering and wait until every awaited result has come out. The
	// count is read at the falling edge, away from the checker's update. The
	// extra cycles cover an item that gives no result but is still in flight.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (results_pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// Both registers, back to back, only while the block is idle.
	task automatic write_settings(input logic [23:0] ticks, input logic [39:0] id);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= {16'd0, ticks};
		@(posedge clk);
		cfg_index <= REG_NODE_ID;
		cfg_data  <= id;
		@(posedge clk);
		cfg_we      <= 1'b0;
		cur_timeout = ticks;
	endtask

	// A few ticks that stay under the timeout (none when it is 1).
	function automatic int spare_ticks();
		if (cur_timeout <= 24'd1)
			return 0;
		return $urandom_range(0, (cur_timeout > 24'd3) ? 2 : int'(cur_timeout) - 1);
	endfunction

	function automatic logic [7:0] not_this(input logic [7:0] avoid);
		logic [7:0] b;
		b = 8'($urandom);
		return (b == avoid) ? ~avoid : b;
	endfunction

	// Short frames; the page program always covers the whole page anyway.
	function automatic logic [7:0] frame_len();
		return 8'($urandom_range(0, 12));
	endfunction

	// One frame: ':', length, address lo/hi, checksum, data. The checksum
	// makes the 8-bit sum zero unless a corrupt frame is asked for.
	task automatic send_frame(input logic [7:0] len, input logic [15:0] addr,
			input bit corrupt, input bit tick_gaps);
		logic [7:0] payload [256];
		logic [7:0] sum;
		sum = len + addr[7:0] + addr[15:8];
		for (int i = 0; i < len; i++) begin
			payload[i] = 8'($urandom);
			sum        = sum + payload[i];
		end
		if (corrupt)
			sum = sum + 8'($urandom_range(1, 255));
		send_item(ACT_BYTE, BYTE_COLON);
		send_item(ACT_BYTE, len);
		send_item(ACT_BYTE, addr[7:0]);
		send_item(ACT_BYTE, addr[15:8]);
		send_item(ACT_BYTE, 8'(-sum));
		for (int i = 0; i < len; i++) begin
			if (tick_gaps && $urandom_range(0, 3) == 0)
				send_ticks(spare_ticks());
			send_item(ACT_BYTE, payload[i]);
		end
	endtask

	// Frame cut off before its checksum, then left to time out.
	task automatic send_cut_frame();
		int cut;
		cut = $urandom_range(0, 3);
		send_item(ACT_BYTE, BYTE_COLON);
		if (cut > 0)
			send_item(ACT_BYTE, not_this(BYTE_S));
		for (int i = 1; i < cut; i++)
			send_item(ACT_BYTE, 8'($urandom));
		send_ticks(cur_timeout);
	endtask

	// One loader session: start, handshake, then a few frames. Most sessions
	// are well formed; some leave early, break frames or throw in noise.
	task automatic run_session();
		int pick;
		send_item(ACT_START, 8'($urandom));
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			send_item(ACT_BYTE, not_this(BYTE_ACK));
			return;
		end
		if (pick == 1 && cur_timeout <= 24'd8) begin
			send_ticks(cur_timeout);
			return;
		end
		send_ticks(spare_ticks());
		send_item(ACT_BYTE, BYTE_ACK);
		repeat ($urandom_range(1, 4)) begin
			pick = $urandom_range(0, 11);
			if (pick == 0) begin
				// 'S' leaves the loader; later items fall on deaf ears
				send_item(ACT_BYTE, BYTE_COLON);
				send_item(ACT_BYTE, BYTE_S);
				send_item(2'($urandom_range(1, 3)), 8'($urandom));
				return;
			end
			if (pick == 1) begin
				// abandon a frame halfway; the next start restarts it all
				send_item(ACT_BYTE, BYTE_COLON);
				send_item(ACT_BYTE, not_this(BYTE_S));
				return;
			end
			if (pick == 2) begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(0, 1) == 0)
						send_item(ACT_BYTE, not_this(BYTE_COLON));
					else
						send_item(ACT_UNUSED, 8'($urandom));
				end
				send_ticks(spare_ticks());
			end
			if (pick == 3 && cur_timeout <= 24'd8)
				send_cut_frame();
			else
				send_frame(frame_len(), 16'($urandom), pick == 4, 1'b1);
			// the sender sometimes waits for the block to go quiet
			if ($urandom_range(0, 5) == 0)
				drain();
		end
	endtask

	// Receiver: random short stalls, one long hold-off when asked, and
	// always ready in the calm tail.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			if (hold_wanted && !hold_taken) begin
				hold_taken = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int target;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_TIMEOUT;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_START;
		items_sent    = 0;
		cur_timeout   = TIMEOUT_RESET;
		calm          = 1'b0;
		hold_wanted   = 1'b0;
		hold_taken    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings first.
		// Idle loader ignores bytes, ticks and the unused action code.
		send_item(ACT_TICK, 8'h00);
		send_item(ACT_BYTE, 8'hFF);
		send_item(ACT_UNUSED, 8'hAA);
		// Handshake with the reset id, then an empty frame at the top address:
		// the page comes from an untouched buffer and the address wraps.
		send_item(ACT_START, 8'h00);
		send_item(ACT_BYTE, BYTE_ACK);
		send_frame(8'd0, 16'hFFFF, 1'b0, 1'b0);
		drain();

		// All-ones id, short timeout.
		write_settings(24'd3, 40'hFF_FFFF_FFFF);
		send_item(ACT_START, 8'hFF);
		send_item(ACT_BYTE, BYTE_ACK);
		send_item(ACT_BYTE, 8'h00);                      // not ':' -> dropped
		send_frame(8'd2, 16'h0000, 1'b1, 1'b0);          // bad checksum -> BEL
		send_ticks(3);                                   // colon wait times out
		send_item(ACT_BYTE, BYTE_COLON);
		send_item(ACT_BYTE, BYTE_S);                     // leave with BS
		send_item(ACT_BYTE, 8'h3A);                      // after exit: ignored
		send_item(ACT_TICK, 8'h00);
		send_item(ACT_START, 8'h00);
		send_ticks(3);                                   // handshake times out
		send_item(ACT_START, 8'h00);
		send_item(ACT_BYTE, 8'h00);                      // wrong reply -> app
		drain();

		// Random part 1: random settings, and the receiver holds off for a long
		// stretch while a frame is offered, so the block backs up.
		write_settings(24'($urandom_range(2, 6)), 40'({$urandom, $urandom}));
		hold_wanted = 1'b1;
		send_item(ACT_START, 8'($urandom));
		send_item(ACT_BYTE, BYTE_ACK);
		send_frame(8'd12, 16'($urandom), 1'b0, 1'b0);
		target = items_sent + 20;
		while (items_sent < target)
			run_session();
		drain();

		// Random part 2: shortest timeout, all-zero id.
		write_settings(24'd1, 40'd0);
		target = items_sent + 20;
		while (items_sent < target)
			run_session();
		drain();

		// Calm tail: longest timeout, no idling on either side.
		write_settings(24'hFFFFFF, 40'({$urandom, $urandom}));
		calm = 1'b1;
		target = items_sent + 15;
		while (items_sent < target)
			run_session();

		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (results_pending != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
